>>> rtl/bpi_pkg.sv
// Shared constants, widths and types of the bicubic interpolation core.
package bpi_pkg;

	function automatic int imax(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

	function automatic int imin(input int a, input int b);
		return (a < b) ? a : b;
	endfunction

	// Format of the ports
	localparam int FRAC_BITS   = 12;
	localparam int PIXEL_BITS  = 8;
	localparam int TAPS        = 4;
	localparam int ROW_FIELD_W = 32;
	localparam int OFS_W       = 12;
	localparam int A_W         = 14;
	localparam int A_FRAC      = 12;

	localparam int WSHIFT     = A_FRAC + 3 * FRAC_BITS;
	localparam int ROW_PAD_W  = imax(TAPS * PIXEL_BITS, ROW_FIELD_W);
	localparam int OFS_EXT_W  = imax(FRAC_BITS, OFS_W);

	localparam logic signed [A_W-1:0] SPLINE_A_RST = A_W'(-4096);
	localparam int S1_OFS = 2 << A_FRAC;
	localparam int S3_OFS = 3 << A_FRAC;
	localparam logic [FRAC_BITS:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

	// Weight generator widths
	localparam int XX_W  = 2 * FRAC_BITS;
	localparam int XU_W  = 2 * FRAC_BITS - 1;
	localparam int UU_W  = 2 * FRAC_BITS + 1;
	localparam int X3_W  = 3 * FRAC_BITS;
	localparam int U3_W  = 3 * FRAC_BITS + 1;
	localparam int S1_W  = A_W;
	localparam int S3_W  = A_W + 1;
	localparam int AXU_W = A_W + XU_W;
	localparam int S3XX_W = S3_W + XX_W;
	localparam int S3UU_W = S3_W + UU_W;
	localparam int T1_W  = S1_W + X3_W;
	localparam int T2_W  = S1_W + U3_W;
	localparam int WGT_W = 3 * FRAC_BITS + 17;
	localparam logic signed [WGT_W-1:0] WGT_ONE =
		{{(WGT_W - WSHIFT - 1){1'b0}}, 1'b1, {WSHIFT{1'b0}}};

	// Horizontal pass
	localparam int HP_W   = WGT_W + PIXEL_BITS + 1;
	localparam int RSUM_W = HP_W + 2;

	// Vertical pass: weights and rows are split in halves
	localparam int WLO_W  = WGT_W / 2;
	localparam int WHI_W  = WGT_W - WLO_W;
	localparam int RLO_W  = RSUM_W / 2;
	localparam int RHI_W  = RSUM_W - RLO_W;
	localparam int LL_W   = WLO_W + RLO_W;
	localparam int HL_W   = WHI_W + RLO_W;
	localparam int LH_W   = WLO_W + RHI_W;
	localparam int HH_W   = WHI_W + RHI_W;
	localparam int SLL_W  = LL_W + 2;
	localparam int SHL_W  = HL_W + 2;
	localparam int SLH_W  = LH_W + 2;
	localparam int SHH_W  = HH_W + 2;
	localparam int LOW_SH = imin(WLO_W, RLO_W);
	localparam int HI_SH  = WLO_W + RLO_W - LOW_SH;
	localparam int C_W    = imax(imax(SHL_W + WLO_W - LOW_SH, SLH_W + RLO_W - LOW_SH),
		SLL_W - LOW_SH + 1) + 2;
	localparam int E_W    = imax(SHH_W, C_W - HI_SH) + 1;
	localparam int T_SH   = 2 * WSHIFT - WLO_W - RLO_W;

	// Pipeline layout
	localparam int WG_STAGES = 4;
	localparam int RF_STAGES = 2;
	localparam int CF_STAGES = 4;
	localparam int ST_ROW    = WG_STAGES;
	localparam int ST_YWG    = ST_ROW + RF_STAGES - WG_STAGES;
	localparam int ST_COL    = ST_ROW + RF_STAGES;
	localparam int N_STAGES  = ST_COL + CF_STAGES;

	typedef logic [ROW_FIELD_W-1:0]   row_t;
	typedef logic [OFS_W-1:0]         ofs_t;
	typedef logic [PIXEL_BITS-1:0]    pix_t;
	typedef logic signed [A_W-1:0]    spline_t;
	typedef logic signed [WGT_W-1:0]  wgt_t;
	typedef logic signed [RSUM_W-1:0] rsum_t;
	typedef pix_t  pix_blk_t [TAPS][TAPS];
	typedef wgt_t  wgt_vec_t [TAPS];
	typedef rsum_t rsum_vec_t [TAPS];

endpackage

>>> rtl/bpi_if.sv
// Handshake channels of the bicubic interpolation core.
interface bpi_nbhd_if;
	logic            valid;
	logic            ready;
	bpi_pkg::row_t   row_top;
	bpi_pkg::row_t   row_upper;
	bpi_pkg::row_t   row_lower;
	bpi_pkg::row_t   row_bottom;
	bpi_pkg::ofs_t   x_frac;
	bpi_pkg::ofs_t   y_frac;

	modport source(output valid, row_top, row_upper, row_lower, row_bottom, x_frac, y_frac,
		input ready);
	modport sink(input valid, row_top, row_upper, row_lower, row_bottom, x_frac, y_frac,
		output ready);
endinterface

interface bpi_result_if;
	logic          valid;
	logic          ready;
	bpi_pkg::pix_t pixel_out;

	modport source(output valid, pixel_out, input ready);
	modport sink(input valid, pixel_out, output ready);
endinterface

interface bpi_cfg_if;
	logic             valid;
	logic             ready;
	bpi_pkg::spline_t spline_a;

	modport source(output valid, spline_a, input ready);
	modport sink(input valid, spline_a, output ready);
endinterface

>>> rtl/bpi_weight_gen.sv
// Four-stage generator of the four cubic convolution weights for one offset.
module bpi_weight_gen (
	input  logic                              clk,
	input  logic [bpi_pkg::WG_STAGES-1:0]     en,
	input  bpi_pkg::ofs_t                     frac,
	input  bpi_pkg::spline_t                  spline_a,
	output bpi_pkg::wgt_vec_t                 wgt
);
	import bpi_pkg::*;

	logic [OFS_EXT_W-1:0]        frac_ext;
	logic [FRAC_BITS-1:0]        x;
	logic [FRAC_BITS:0]          u;
	logic signed [A_W+1:0]       s1_full;
	logic signed [A_W+1:0]       s3_full;
	logic [2*FRAC_BITS-1:0]      xx_full;
	logic [2*FRAC_BITS:0]        xu_full;
	logic [2*FRAC_BITS+1:0]      uu_full;

	logic [FRAC_BITS-1:0]        x_s1;
	logic [FRAC_BITS:0]          u_s1;
	spline_t                     a_s1;
	logic [S1_W-1:0]             s1_s1;
	logic [S3_W-1:0]             s3_s1;
	logic [XX_W-1:0]             xx_s1;
	logic [XU_W-1:0]             xu_s1;
	logic [UU_W-1:0]             uu_s1;

	logic [X3_W-1:0]             x3_full;
	logic [3*FRAC_BITS+1:0]      u3_full;
	logic signed [AXU_W:0]       axu_full;

	logic [FRAC_BITS-1:0]        x_s2;
	logic [FRAC_BITS:0]          u_s2;
	logic [S1_W-1:0]             s1_s2;
	logic [X3_W-1:0]             x3_s2;
	logic [U3_W-1:0]             u3_s2;
	logic signed [AXU_W-1:0]     axu_s2;
	logic [S3XX_W-1:0]           s3xx_s2;
	logic [S3UU_W-1:0]           s3uu_s2;

	logic signed [AXU_W+FRAC_BITS+1:0] w0_full;
	logic signed [AXU_W+FRAC_BITS:0]   w3_full;

	wgt_t                        w0_s3;
	wgt_t                        w3_s3;
	logic [T1_W-1:0]             t1_s3;
	logic [T2_W-1:0]             t2_s3;
	logic [S3XX_W-1:0]           s3xx_s3;
	logic [S3UU_W-1:0]           s3uu_s3;

	wgt_t                        w_s4 [TAPS];

	always_comb begin
		frac_ext = OFS_EXT_W'(frac);
		x        = frac_ext[FRAC_BITS-1:0];
		u        = FRAC_ONE - {1'b0, x};
		s1_full  = (A_W+2)'(spline_a) + (A_W+2)'(S1_OFS);
		s3_full  = (A_W+2)'(spline_a) + (A_W+2)'(S3_OFS);
		xx_full  = x * x;
		xu_full  = x * u;
		uu_full  = u * u;
		x3_full  = xx_s1 * x_s1;
		u3_full  = uu_s1 * u_s1;
		axu_full = $signed(a_s1) * $signed({1'b0, xu_s1});
		w0_full  = $signed(axu_s2) * $signed({1'b0, u_s2});
		w3_full  = $signed(axu_s2) * $signed({1'b0, x_s2});
	end

	// x*x, x*u, u*u
	always_ff @(posedge clk) begin
		if (en[0]) begin
			x_s1  <= x;
			u_s1  <= u;
			a_s1  <= spline_a;
			s1_s1 <= s1_full[S1_W-1:0];
			s3_s1 <= s3_full[S3_W-1:0];
			xx_s1 <= xx_full;
			xu_s1 <= xu_full[XU_W-1:0];
			uu_s1 <= uu_full[UU_W-1:0];
		end
	end

	// cubes, a*x*u, (a+3)*x^2, (a+3)*u^2
	always_ff @(posedge clk) begin
		if (en[1]) begin
			x_s2    <= x_s1;
			u_s2    <= u_s1;
			s1_s2   <= s1_s1;
			x3_s2   <= x3_full;
			u3_s2   <= u3_full[U3_W-1:0];
			axu_s2  <= axu_full[AXU_W-1:0];
			s3xx_s2 <= s3_s1 * xx_s1;
			s3uu_s2 <= s3_s1 * uu_s1;
		end
	end

	// outer weights complete, (a+2)*cubes
	always_ff @(posedge clk) begin
		if (en[2]) begin
			w0_s3   <= WGT_W'(w0_full);
			w3_s3   <= WGT_W'(w3_full);
			t1_s3   <= s1_s2 * x3_s2;
			t2_s3   <= s1_s2 * u3_s2;
			s3xx_s3 <= s3xx_s2;
			s3uu_s3 <= s3uu_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			w_s4[0] <= w0_s3;
			w_s4[1] <= $signed(WGT_W'(t1_s3))
				- $signed(WGT_W'({s3xx_s3, {FRAC_BITS{1'b0}}})) + WGT_ONE;
			w_s4[2] <= $signed(WGT_W'(t2_s3))
				- $signed(WGT_W'({s3uu_s3, {FRAC_BITS{1'b0}}})) + WGT_ONE;
			w_s4[3] <= w3_s3;
		end
	end

	assign wgt = w_s4;

endmodule

>>> rtl/bpi_row_filter.sv
// Horizontal pass: four taps per row, products then row sums.
module bpi_row_filter (
	input  logic                          clk,
	input  logic [bpi_pkg::RF_STAGES-1:0] en,
	input  bpi_pkg::pix_blk_t             pix,
	input  bpi_pkg::wgt_vec_t             wx,
	output bpi_pkg::rsum_vec_t            row
);
	import bpi_pkg::*;

	logic signed [HP_W-1:0] prod_s1 [TAPS][TAPS];
	rsum_t                  row_sum [TAPS];
	rsum_t                  row_s2  [TAPS];

	always_comb begin
		for (int j = 0; j < TAPS; j++) begin
			row_sum[j] = '0;
			for (int k = 0; k < TAPS; k++) begin
				row_sum[j] = row_sum[j] + RSUM_W'(prod_s1[j][k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int j = 0; j < TAPS; j++) begin
				for (int k = 0; k < TAPS; k++) begin
					prod_s1[j][k] <= $signed(wx[k]) * $signed({1'b0, pix[j][k]});
				end
			end
		end
		if (en[1]) begin
			row_s2 <= row_sum;
		end
	end

	assign row = row_s2;

endmodule

>>> rtl/bpi_col_filter.sv
// Vertical pass: split products, partial sums, exact floor and clamp.
module bpi_col_filter (
	input  logic                          clk,
	input  logic [bpi_pkg::CF_STAGES-1:0] en,
	input  bpi_pkg::rsum_vec_t            row,
	input  bpi_pkg::wgt_vec_t             wy,
	output bpi_pkg::pix_t                 pixel
);
	import bpi_pkg::*;

	logic [WLO_W-1:0]        wlo [TAPS];
	logic [WHI_W-1:0]        whi [TAPS];
	logic [RLO_W-1:0]        rlo [TAPS];
	logic [RHI_W-1:0]        rhi [TAPS];
	logic signed [HL_W:0]    hl_full [TAPS];

	logic [LL_W-1:0]         ll_s1 [TAPS];
	logic signed [HL_W-1:0]  hl_s1 [TAPS];
	logic signed [LH_W-1:0]  lh_s1 [TAPS];
	logic signed [HH_W-1:0]  hh_s1 [TAPS];

	logic [SLL_W-1:0]        sll;
	logic signed [SHL_W-1:0] shl;
	logic signed [SLH_W-1:0] slh;
	logic signed [SHH_W-1:0] shh;

	logic [SLL_W-1:0]        sll_s2;
	logic signed [SHL_W-1:0] shl_s2;
	logic signed [SLH_W-1:0] slh_s2;
	logic signed [SHH_W-1:0] shh_s2;

	logic signed [C_W-1:0]   c_s3;
	logic signed [SHH_W-1:0] shh_s3;

	logic signed [E_W-1:0]   e;
	pix_t                    clamped;
	pix_t                    pixel_s4;

	always_comb begin
		for (int j = 0; j < TAPS; j++) begin
			wlo[j]     = wy[j][WLO_W-1:0];
			whi[j]     = wy[j][WGT_W-1:WLO_W];
			rlo[j]     = row[j][RLO_W-1:0];
			rhi[j]     = row[j][RSUM_W-1:RLO_W];
			hl_full[j] = $signed(whi[j]) * $signed({1'b0, rlo[j]});
		end
	end

	always_comb begin
		sll = '0;
		shl = '0;
		slh = '0;
		shh = '0;
		for (int j = 0; j < TAPS; j++) begin
			sll = sll + SLL_W'(ll_s1[j]);
			shl = shl + SHL_W'(hl_s1[j]);
			slh = slh + SLH_W'(lh_s1[j]);
			shh = shh + SHH_W'(hh_s1[j]);
		end
	end

	// total = hh<<(WLO+RLO) + hl<<WLO + lh<<RLO + ll; floor taken in two steps
	always_comb begin
		e = E_W'(shh_s3) + E_W'(c_s3 >>> HI_SH);
		if (e[E_W-1]) begin
			clamped = '0;
		end else if (|e[E_W-2:T_SH+PIXEL_BITS]) begin
			clamped = '1;
		end else begin
			clamped = e[T_SH +: PIXEL_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int j = 0; j < TAPS; j++) begin
				ll_s1[j] <= wlo[j] * rlo[j];
				hl_s1[j] <= hl_full[j][HL_W-1:0];
				lh_s1[j] <= $signed({1'b0, wlo[j]}) * $signed(rhi[j]);
				hh_s1[j] <= $signed(whi[j]) * $signed(rhi[j]);
			end
		end
		if (en[1]) begin
			sll_s2 <= sll;
			shl_s2 <= shl;
			slh_s2 <= slh;
			shh_s2 <= shh;
		end
		if (en[2]) begin
			c_s3   <= C_W'(sll_s2 >> LOW_SH) + (C_W'(shl_s2) <<< (WLO_W - LOW_SH))
				+ (C_W'(slh_s2) <<< (RLO_W - LOW_SH));
			shh_s3 <= shh_s2;
		end
		if (en[3]) begin
			pixel_s4 <= clamped;
		end
	end

	assign pixel = pixel_s4;

endmodule

>>> rtl/bicubic_pixel_interpolation_core.sv
// Bicubic pixel interpolation core: 4x4 neighborhood in, one pixel out.
// Ten register stages: weight generation, then the row filter, then the column filter.
// Throughput: one word per cycle unless result.ready stalls; one enable per stage.
// A stalled output holds only the stages that carry data, so bubbles still fill behind it.
// Reset clears all stage valid bits and loads spline_a with -1.0 (-4096).
module bicubic_pixel_interpolation_core (
	input  logic         clk,
	input  logic         arst_n,
	bpi_nbhd_if.sink     nbhd,
	bpi_result_if.source result,
	bpi_cfg_if.sink      cfg
);
	import bpi_pkg::*;

	spline_t               spline_a_q;
	logic [N_STAGES-1:0]   vld_q;
	logic [N_STAGES-1:0]   en;

	row_t                  row_in  [TAPS];
	logic [ROW_PAD_W-1:0]  row_pad [TAPS];
	pix_blk_t              pix_in;
	pix_blk_t              pix_s1;
	pix_blk_t              pix_s2;
	pix_blk_t              pix_s3;
	pix_blk_t              pix_s4;
	ofs_t                  y_frac_s1;
	ofs_t                  y_frac_s2;

	wgt_vec_t              wx;
	wgt_vec_t              wy;
	rsum_vec_t             row_val;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spline_a_q <= SPLINE_A_RST;
		end else if (cfg.valid) begin
			spline_a_q <= cfg.spline_a;
		end
	end

	// A stage moves when it is empty or the stage after it moves.
	always_comb begin
		en[N_STAGES-1] = ~vld_q[N_STAGES-1] | result.ready;
		for (int k = N_STAGES - 2; k >= 0; k--) begin
			en[k] = ~vld_q[k] | en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= nbhd.valid;
			end
			for (int k = 1; k < N_STAGES; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign nbhd.ready       = en[0];
	assign result.valid     = vld_q[N_STAGES-1];

	always_comb begin
		row_in[0] = nbhd.row_top;
		row_in[1] = nbhd.row_upper;
		row_in[2] = nbhd.row_lower;
		row_in[3] = nbhd.row_bottom;
		for (int j = 0; j < TAPS; j++) begin
			row_pad[j] = ROW_PAD_W'(row_in[j]);
			for (int k = 0; k < TAPS; k++) begin
				pix_in[j][k] = row_pad[j][k*PIXEL_BITS +: PIXEL_BITS];
			end
		end
	end

	// pixels wait for the horizontal weights; y offset waits two stages
	always_ff @(posedge clk) begin
		if (en[0]) begin
			pix_s1    <= pix_in;
			y_frac_s1 <= nbhd.y_frac;
		end
		if (en[1]) begin
			pix_s2    <= pix_s1;
			y_frac_s2 <= y_frac_s1;
		end
		if (en[2]) begin
			pix_s3 <= pix_s2;
		end
		if (en[3]) begin
			pix_s4 <= pix_s3;
		end
	end

	bpi_weight_gen u_wgen_x (
		.clk      (clk),
		.en       (en[0 +: WG_STAGES]),
		.frac     (nbhd.x_frac),
		.spline_a (spline_a_q),
		.wgt      (wx)
	);

	bpi_weight_gen u_wgen_y (
		.clk      (clk),
		.en       (en[ST_YWG +: WG_STAGES]),
		.frac     (y_frac_s2),
		.spline_a (spline_a_q),
		.wgt      (wy)
	);

	bpi_row_filter u_row (
		.clk (clk),
		.en  (en[ST_ROW +: RF_STAGES]),
		.pix (pix_s4),
		.wx  (wx),
		.row (row_val)
	);

	bpi_col_filter u_col (
		.clk   (clk),
		.en    (en[ST_COL +: CF_STAGES]),
		.row   (row_val),
		.wy    (wy),
		.pixel (result.pixel_out)
	);

endmodule
